>>> rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared constants, word types and state codes of the text console engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int LINE_W     = 5;
	localparam int COL_W      = 7;

	localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0]  CHAR_RETURN  = 8'h0D;
	localparam logic [7:0]  CHAR_BLANK   = 8'h20;
	localparam logic [15:0] CELL_RESET   = 16'h0720;
	localparam logic [3:0]  FG_RESET     = 4'h7;
	localparam logic [3:0]  BG_RESET     = 4'h0;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_BKSP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DRAIN,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} in_word_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_now;
		logic [COL_W-1:0]  column_now;
		logic [15:0]       cell_word;
		logic              did_scroll;
	} out_word_t;

endpackage

`default_nettype wire

>>> rtl/core/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell screen store with a cursor, scrolling, backspace and clear.
// ----------------------------------------------------------------------------
//   channel  | handshake              | word
//   in       | in_valid / in_ready    | in_data  (operation, char, address)
//   out      | out_valid / out_ready  | out_data (line, column, cell, scroll)
//   cfg      | cfg_we                 | cfg_index, cfg_data (colors)
//
// A put, carriage return, backspace or in-range read goes from acceptance
// through the execute state (and for a read the read-wait state) to the
// response state, which registers the output word; in_ready returns in that
// same cycle, so a new word is taken only after the last one is answered.
// A scroll or clear walks the whole store through the single RAM port pair,
// one cell per cycle. After reset the same walk blanks it, with in_ready low.
// A stalled output word holds the engine in its response state until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tcce_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tcce_pkg::out_word_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [3:0]          cfg_data
);

	import tcce_pkg::*;

	state_t            state_q, state_d;
	logic [3:0]        fg_q, bg_q;
	logic [LINE_W-1:0] line_q, line_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [1:0]        op_q;
	logic [7:0]        ch_q;
	logic [10:0]       addr_q;
	logic [15:0]       word_q, word_d;
	logic              scroll_q, scroll_d;
	logic              init_q, init_d;
	logic              copy_q, copy_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              out_valid_q;
	out_word_t         out_q;

	logic              wr_v_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [15:0]       wr_blank_s1;

	logic              ram_we, exec_we;
	logic [ADDR_W-1:0] ram_waddr, exec_waddr;
	logic [15:0]       ram_wdata, exec_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	logic [15:0]       blank_cell;
	logic [ADDR_W-1:0] cur_addr;
	logic              in_fire;
	logic              out_free;

	assign blank_cell = {bg_q, fg_q, CHAR_BLANK};
	assign cur_addr   = ADDR_W'(ADDR_W'(line_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FG: fg_q <= cfg_data;
				REG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WALK;
			line_q   <= '0;
			col_q    <= '0;
			init_q   <= 1'b1;
			copy_q   <= 1'b0;
			idx_q    <= '0;
			word_q   <= '0;
			scroll_q <= 1'b0;
			wr_v_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			line_q   <= line_d;
			col_q    <= col_d;
			init_q   <= init_d;
			copy_q   <= copy_d;
			idx_q    <= idx_d;
			word_q   <= word_d;
			scroll_q <= scroll_d;
			wr_v_s1  <= (state_q == ST_WALK);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= in_data.operation;
			ch_q   <= in_data.char_code;
			addr_q <= in_data.cell_address;
		end
		wr_addr_s1  <= idx_q;
		wr_copy_s1  <= copy_q && (idx_q < ADDR_W'(CELL_COUNT - COLUMNS));
		wr_blank_s1 <= init_q ? CELL_RESET : blank_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_q.line_now   <= line_q;
			out_q.column_now <= col_q;
			out_q.cell_word  <= word_q;
			out_q.did_scroll <= scroll_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		line_d     = line_q;
		col_d      = col_q;
		init_d     = init_q;
		copy_d     = copy_q;
		idx_d      = idx_q;
		word_d     = word_q;
		scroll_d   = scroll_q;
		exec_we    = 1'b0;
		exec_waddr = cur_addr;
		exec_wdata = {bg_q, fg_q, ch_q};
		ram_re     = 1'b0;
		ram_raddr  = idx_q + ADDR_W'(COLUMNS);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					word_d   = '0;
					scroll_d = 1'b0;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_RESP;
				unique case (op_t'(op_q))
					OP_PUT: begin
						if (ch_q == CHAR_RETURN) begin
							col_d = '0;
						end else if (ch_q != CHAR_NEWLINE && col_q != COL_W'(COLUMNS - 1)) begin
							exec_we = 1'b1;
							col_d   = col_q + 1'b1;
						end else begin
							exec_we = (ch_q != CHAR_NEWLINE);
							col_d   = '0;
							if (line_q == LINE_W'(ROWS - 1)) begin
								scroll_d = 1'b1;
								copy_d   = 1'b1;
								idx_d    = '0;
								state_d  = ST_WALK;
							end else begin
								line_d = line_q + 1'b1;
							end
						end
					end
					OP_BKSP: begin
						if (col_q != '0 || line_q != '0) begin
							exec_we    = 1'b1;
							exec_waddr = cur_addr - 1'b1;
							exec_wdata = blank_cell;
							if (col_q == '0) begin
								col_d  = COL_W'(COLUMNS - 1);
								line_d = line_q - 1'b1;
							end else begin
								col_d = col_q - 1'b1;
							end
						end
					end
					OP_CLEAR: begin
						line_d  = '0;
						col_d   = '0;
						copy_d  = 1'b0;
						idx_d   = '0;
						state_d = ST_WALK;
					end
					OP_READ: begin
						if (addr_q < 11'(CELL_COUNT)) begin
							ram_re    = 1'b1;
							ram_raddr = addr_q[ADDR_W-1:0];
							state_d   = ST_RDWAIT;
						end
					end
					default: ;
				endcase
			end
			ST_WALK: begin
				ram_re = copy_q && (idx_q < ADDR_W'(CELL_COUNT - COLUMNS));
				idx_d  = idx_q + 1'b1;
				if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				init_d  = 1'b0;
				state_d = init_q ? ST_IDLE : ST_RESP;
			end
			ST_RDWAIT: begin
				word_d  = ram_rdata;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_copy_s1 ? ram_rdata : wr_blank_s1;
		end else begin
			ram_we    = exec_we;
			ram_waddr = exec_waddr;
			ram_wdata = exec_wdata;
		end
	end

	tcce_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/core/tcce_checker.sv
// ----------------------------------------------------------------------------
// Text console checker
// Port-level properties of the text console engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire tcce_pkg::out_word_t out_data
);

	import tcce_pkg::*;

	// A stalled output word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// The engine takes one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted in back-to-back cycles");

	// The reported cursor is always on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.line_now < LINE_W'(ROWS))
			&& (out_data.column_now < COL_W'(COLUMNS)))
		else $error("cursor outside the screen");

	// A scroll leaves the cursor at the start of the bottom line.
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.did_scroll |-> (out_data.line_now == LINE_W'(ROWS - 1))
			&& (out_data.column_now == '0))
		else $error("scroll left the cursor off the bottom line start");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

`default_nettype wire
